[hw/rtl/point_in_polygon_test_top_defines.svh]
// ----------------------------------------------------------------------------
// point_in_polygon_test_top_defines
// assertion macros shared by the point-in-polygon rtl
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// clocked check, off while reset is asserted
`define PIP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pip assertion failed");

// clocked check, also active during reset
`define PIP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pip assertion failed");

`else

`define PIP_ASSERT(label, clk, rst_n, prop)
`define PIP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[hw/rtl/pip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// types and constants of the point-in-polygon crossing-number block
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int CntW = 9;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [7:0]         vertex_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
  } in_word_t;

  typedef struct packed {
    logic            inside_res;
    logic [CntW-1:0] crossings;
  } out_word_t;

  // sequencer to edge pipeline
  typedef struct packed {
    logic clr;
    logic rd_vld;
    logic rd_first;
    logic close;
  } edge_ctrl_t;

  // edge pipeline to sequencer
  typedef struct packed {
    logic            done;
    logic [CntW-1:0] count;
  } edge_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_EMIT
  } seq_state_e;

endpackage

[hw/rtl/pip_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/pip_edge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_edge
// edge test pipeline: pairs consecutive vertices, tests one edge a cycle
// ----------------------------------------------------------------------------
module pip_edge #(
  parameter int CoordBits = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pip_pkg::edge_ctrl_t         ctrl_i,
  input  logic signed [CoordBits-1:0] qx_i,
  input  logic signed [CoordBits-1:0] qy_i,
  input  logic [2*CoordBits-1:0]      rdata_i,
  output pip_pkg::edge_stat_t         stat_o
);

  localparam int DW = CoordBits + 1;
  localparam int PW = 2 * CoordBits + 2;

  // vertex token: ram data, or the first vertex again for the closing edge
  logic                        tok_vld;
  logic                        e_vld;
  logic signed [CoordBits-1:0] rd_x, rd_y, tok_x, tok_y;
  logic signed [CoordBits-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;

  // stage 1 compare and differences
  logic signed [CoordBits-1:0] ylo, yhi, xhi;
  logic                        pre_ok, vert, dy_pos;
  logic signed [DW-1:0]        dy, dxp, dyp, dx;

  logic                 s1_vld_q, s1_last_q;
  logic                 s1_pre_ok_q, s1_vert_q, s1_dy_pos_q;
  logic signed [DW-1:0] s1_dy_q, s1_dxp_q, s1_dyp_q, s1_dx_q;

  // stage 2 products
  logic                 s2_vld_q, s2_last_q;
  logic                 s2_pre_ok_q, s2_vert_q, s2_dy_pos_q;
  logic signed [PW-1:0] lhs_d, rhs_d, lhs_q, rhs_q;

  // stage 3 accumulate
  logic                         hit;
  logic                         done_d, done_q;
  logic [pip_pkg::CntW-1:0]     count_d, count_q;

  always_comb begin
    rd_x    = $signed(rdata_i[2*CoordBits-1:CoordBits]);
    rd_y    = $signed(rdata_i[CoordBits-1:0]);
    tok_vld = ctrl_i.rd_vld | ctrl_i.close;
    tok_x   = ctrl_i.close ? first_x_q : rd_x;
    tok_y   = ctrl_i.close ? first_y_q : rd_y;
    e_vld   = tok_vld && !(ctrl_i.rd_vld && ctrl_i.rd_first);
  end

  // edge runs from prev (x1,y1) to tok (x2,y2)
  always_comb begin
    ylo    = (prev_y_q < tok_y) ? prev_y_q : tok_y;
    yhi    = (prev_y_q < tok_y) ? tok_y : prev_y_q;
    xhi    = (prev_x_q < tok_x) ? tok_x : prev_x_q;
    pre_ok = (qy_i > ylo) && (qy_i <= yhi) && (qx_i <= xhi) && (prev_y_q != tok_y);
    vert   = (prev_x_q == tok_x);
    dy_pos = (tok_y > prev_y_q);
    dy     = DW'(tok_y) - DW'(prev_y_q);
    dxp    = DW'(qx_i) - DW'(prev_x_q);
    dyp    = DW'(qy_i) - DW'(prev_y_q);
    dx     = DW'(tok_x) - DW'(prev_x_q);
  end

  assign lhs_d = PW'(s1_dxp_q) * PW'(s1_dy_q);
  assign rhs_d = PW'(s1_dyp_q) * PW'(s1_dx_q);

  always_comb begin
    hit = s2_pre_ok_q && (s2_vert_q || (s2_dy_pos_q ? (lhs_q <= rhs_q) : (lhs_q >= rhs_q)));
    count_d = count_q;
    if (ctrl_i.clr) begin
      count_d = '0;
    end else if (s2_vld_q) begin
      count_d = count_q + pip_pkg::CntW'(hit);
    end
    done_d = s2_vld_q && s2_last_q && !ctrl_i.clr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
      done_q    <= 1'b0;
      count_q   <= '0;
    end else begin
      s1_vld_q  <= e_vld;
      s1_last_q <= ctrl_i.close;
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;
      done_q    <= done_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_vld && ctrl_i.rd_first) begin
      first_x_q <= rd_x;
      first_y_q <= rd_y;
    end
    if (tok_vld) begin
      prev_x_q <= tok_x;
      prev_y_q <= tok_y;
    end
    s1_pre_ok_q <= pre_ok;
    s1_vert_q   <= vert;
    s1_dy_pos_q <= dy_pos;
    s1_dy_q     <= dy;
    s1_dxp_q    <= dxp;
    s1_dyp_q    <= dyp;
    s1_dx_q     <= dx;
    s2_pre_ok_q <= s1_pre_ok_q;
    s2_vert_q   <= s1_vert_q;
    s2_dy_pos_q <= s1_dy_pos_q;
    lhs_q       <= lhs_d;
    rhs_q       <= rhs_d;
  end

  assign stat_o.done  = done_q;
  assign stat_o.count = count_q;

endmodule

[hw/rtl/pip_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_seq
// command sequencer: vertex writes, vertex read sweep and result hand-off
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_top_defines.svh"

module pip_seq #(
  parameter int MaxVertices = 256,
  parameter int CoordBits   = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  pip_pkg::in_word_t                  in_word_i,
  input  logic [pip_pkg::CntW-1:0]           vertex_count_i,
  input  logic                               out_free_i,
  output logic                               res_load_o,
  input  pip_pkg::edge_stat_t                stat_i,
  output pip_pkg::edge_ctrl_t                ctrl_o,
  output logic signed [CoordBits-1:0]        qx_o,
  output logic signed [CoordBits-1:0]        qy_o,
  output logic                               we_o,
  output logic [$clog2(MaxVertices)-1:0]     waddr_o,
  output logic [2*CoordBits-1:0]             wdata_o,
  output logic                               re_o,
  output logic [$clog2(MaxVertices)-1:0]     raddr_o
);

  localparam int AW   = $clog2(MaxVertices);
  localparam int NW   = $clog2(MaxVertices + 1);
  localparam int CmpW = (NW > pip_pkg::CntW) ? NW : pip_pkg::CntW;

  pip_pkg::seq_state_e state_d, state_q;

  logic            accept, acc_query, acc_write;
  logic [CmpW-1:0] cnt_ext, cap;
  logic [NW-1:0]   n_eff, n_q;
  logic            idx_ok, rd_last;
  logic [AW-1:0]   rd_cnt_q;
  logic            rd_vld_q, rd_first_q, rd_last_q, close_q;
  logic [CoordBits-1:0] cx, cy;

  always_comb begin
    accept    = in_valid_i && in_ready_o;
    acc_query = accept && (in_word_i.cmd == pip_pkg::CMD_QUERY);
    acc_write = accept && (in_word_i.cmd == pip_pkg::CMD_WRITE);
    cnt_ext   = CmpW'(vertex_count_i);
    cap       = CmpW'(MaxVertices);
    n_eff     = NW'((cnt_ext > cap) ? cap : cnt_ext);
    idx_ok    = CmpW'(in_word_i.vertex_index) < cap;
    rd_last   = (NW'(rd_cnt_q) == (n_q - NW'(1)));
    // low coordinate bits, as a signed coordinate of the stored width
    cx        = CoordBits'($unsigned(in_word_i.coord_x));
    cy        = CoordBits'($unsigned(in_word_i.coord_y));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pip_pkg::ST_IDLE: begin
        if (acc_query) begin
          state_d = (n_eff == '0) ? pip_pkg::ST_EMIT : pip_pkg::ST_READ;
        end
      end
      pip_pkg::ST_READ: begin
        if (rd_last) begin
          state_d = pip_pkg::ST_DRAIN;
        end
      end
      pip_pkg::ST_DRAIN: begin
        if (stat_i.done) begin
          state_d = pip_pkg::ST_EMIT;
        end
      end
      pip_pkg::ST_EMIT: begin
        if (out_free_i) begin
          state_d = pip_pkg::ST_IDLE;
        end
      end
      default: state_d = pip_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    re_o       = 1'b0;
    res_load_o = 1'b0;
    case (state_q)
      pip_pkg::ST_IDLE:  in_ready_o = 1'b1;
      pip_pkg::ST_READ:  re_o       = 1'b1;
      pip_pkg::ST_DRAIN: re_o       = 1'b0;
      pip_pkg::ST_EMIT:  res_load_o = out_free_i;
      default:           re_o       = 1'b0;
    endcase
    we_o    = acc_write && idx_ok;
    waddr_o = AW'(in_word_i.vertex_index);
    wdata_o = {cx, cy};
    raddr_o = rd_cnt_q;
    ctrl_o.clr      = acc_query;
    ctrl_o.rd_vld   = rd_vld_q;
    ctrl_o.rd_first = rd_first_q;
    ctrl_o.close    = close_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pip_pkg::ST_IDLE;
      rd_cnt_q   <= '0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
      rd_last_q  <= 1'b0;
      close_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= re_o;
      rd_first_q <= re_o && (rd_cnt_q == '0);
      rd_last_q  <= re_o && rd_last;
      close_q    <= rd_vld_q && rd_last_q;
      if (acc_query) begin
        rd_cnt_q <= '0;
      end else if (re_o) begin
        rd_cnt_q <= rd_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_query) begin
      n_q  <= n_eff;
      qx_o <= cx;
      qy_o <= cy;
    end
  end

  `PIP_ASSERT(a_done_in_drain, clk_i, rst_ni, stat_i.done |-> state_q == pip_pkg::ST_DRAIN)
  `PIP_ASSERT(a_idle_no_tokens, clk_i, rst_ni, state_q == pip_pkg::ST_IDLE |-> !rd_vld_q && !close_q)
  `PIP_ASSERT(a_query_reads, clk_i, rst_ni, acc_query && n_eff != '0 |=> state_q == pip_pkg::ST_READ)

endmodule

[hw/rtl/point_in_polygon_test_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_top
// crossing-number point-in-polygon test over a stored polygon
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  in      | input     | in_valid_i/in_ready_o   | in_word_i  (cmd, index, x, y)
//  out     | output    | out_valid_o/out_ready_i | out_word_o (inside, crossings)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (vertex_count)
//
//  with n = min(vertex_count, MaxVertices) >= 1 a query sweeps all n vertices,
//  paced by the single ram read port (one vertex, so one edge, per cycle),
//  through the three-stage edge pipe; an empty polygon skips the read sweep;
//  queries run one at a time; the in channel is taken again once the result
//  sits in the output register, even if the out side stalls it there
//  reset clears control and the vertex count; ram contents stay undefined
//  cfg is always ready
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_top_defines.svh"

module point_in_polygon_test_top #(
  parameter int MaxVertices = 256,
  parameter int CoordBits   = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  pip_pkg::in_word_t         in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pip_pkg::out_word_t        out_word_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pip_pkg::CntW-1:0]  cfg_data_i
);

  localparam int AW = $clog2(MaxVertices);

  // configuration register
  logic [pip_pkg::CntW-1:0] vertex_count_q;

  // output register
  logic               out_valid_q;
  pip_pkg::out_word_t out_word_q;
  logic               out_free;
  logic               res_load;

  // sequencer <-> edge pipe
  pip_pkg::edge_ctrl_t         ctrl;
  pip_pkg::edge_stat_t         stat;
  logic signed [CoordBits-1:0] qx, qy;

  // vertex ram ports, word is {x, y}
  logic                   we, re;
  logic [AW-1:0]          waddr, raddr;
  logic [2*CoordBits-1:0] wdata, rdata;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vertex_count_q <= cfg_data_i;
    end
  end

  pip_seq #(
    .MaxVertices(MaxVertices),
    .CoordBits  (CoordBits)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_word_i     (in_word_i),
    .vertex_count_i(vertex_count_q),
    .out_free_i    (out_free),
    .res_load_o    (res_load),
    .stat_i        (stat),
    .ctrl_o        (ctrl),
    .qx_o          (qx),
    .qy_o          (qy),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .re_o          (re),
    .raddr_o       (raddr)
  );

  // vertex store, read once per vertex during a query
  pip_ram #(
    .Width(2 * CoordBits),
    .Depth(MaxVertices)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // edge test and crossing counter
  pip_edge #(
    .CoordBits(CoordBits)
  ) u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .qx_i   (qx),
    .qy_i   (qy),
    .rdata_i(rdata),
    .stat_o (stat)
  );

  // result word: parity of the count is the inside flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_word_q.inside_res <= stat.count[0];
      out_word_q.crossings  <= stat.count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `PIP_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |=> !out_valid_o)

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the point-in-polygon crossing-number block
//
// vertex words and query words go in on a valid/ready channel; every query
// word is predicted from a local copy of the polygon and vertex count and
// compared field by field with the result word that comes out. the vertex
// count is set through the cfg channel only while the block is idle. a
// short directed part covers the coordinate extremes and the empty, single
// vertex and boundary cases. random polygons follow, mostly small with a few
// of full size and with a count above capacity. both sides stall in bursts
// ----------------------------------------------------------------------------

// tracks the polygon as the block sees it and holds the results still due
class polygon_checker;
  logic signed [15:0]  vert_x [256];
  logic signed [15:0]  vert_y [256];
  logic [8:0]          vertex_count;
  pip_pkg::out_word_t  due_q [$];
  int                  errors;

  function new();
    vertex_count = '0;
    errors       = 0;
    foreach (vert_x[i]) begin
      vert_x[i] = '0;
      vert_y[i] = '0;
    end
  endfunction

  function void note_count(logic [8:0] value);
    vertex_count = value;
  endfunction

  // one edge against a ray from (px, py) toward +x, exact by cross-multiplying
  function bit edge_crossed(longint x1, longint y1, longint x2, longint y2,
                            longint px, longint py);
    longint ylo, yhi, xhi, dy, lhs, rhs;
    ylo = (y1 < y2) ? y1 : y2;
    yhi = (y1 < y2) ? y2 : y1;
    xhi = (x1 < x2) ? x2 : x1;
    if (py <= ylo || py > yhi || px > xhi || y1 == y2) return 1'b0;
    if (x1 == x2) return 1'b1;
    dy  = y2 - y1;
    lhs = (px - x1) * dy;
    rhs = (py - y1) * (x2 - x1);
    return (dy > 0) ? (lhs <= rhs) : (lhs >= rhs);
  endfunction

  function pip_pkg::out_word_t ray_crossings(logic signed [15:0] px,
                                             logic signed [15:0] py);
    int                 n, j, hits;
    pip_pkg::out_word_t verdict;
    n    = (vertex_count > 9'd256) ? 256 : int'(vertex_count);
    hits = 0;
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      if (edge_crossed(vert_x[i], vert_y[i], vert_x[j], vert_y[j], px, py)) hits++;
    end
    verdict.inside_res = hits[0];
    verdict.crossings  = (hits > 511) ? 9'd511 : hits[8:0];
    return verdict;
  endfunction

  function void note_input(pip_pkg::in_word_t w);
    if (w.cmd == pip_pkg::CMD_WRITE) begin
      vert_x[w.vertex_index] = w.coord_x;
      vert_y[w.vertex_index] = w.coord_y;
    end else begin
      due_q.insert(due_q.size(), ray_crossings(w.coord_x, w.coord_y));
    end
  endfunction

  task report(string what);
    errors++;
    $display("tb: mismatch at %0t ns: %s", $time, what);
  endtask

  task check_result(pip_pkg::out_word_t got);
    pip_pkg::out_word_t want;
    if (due_q.size() == 0) begin
      report($sformatf("result word with no query waiting (inside %0d, crossings %0d)",
                       got.inside_res, got.crossings));
      return;
    end
    want = due_q.pop_front();
    if (got.inside_res !== want.inside_res)
      report($sformatf("inside_res %0d, want %0d", got.inside_res, want.inside_res));
    if (got.crossings !== want.crossings)
      report($sformatf("crossings %0d, want %0d", got.crossings, want.crossings));
  endtask

  function int pending();
    return due_q.size();
  endfunction
endclass

module tb;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned ItemGoal   = 1600;
  localparam int unsigned QuietFrom  = 1450;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  pip_pkg::in_word_t         in_word_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  pip_pkg::out_word_t        out_word_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [pip_pkg::CntW-1:0]  cfg_data_i  = '0;

  polygon_checker book;
  bit             slot_written [256];
  bit             quiet   = 1'b0;   // last part of the run: no stalls at all
  bit             idle_on = 1'b0;   // sender gaps allowed in this phase
  int unsigned    items_sent = 0;
  int unsigned    cycles     = 0;

  // receiver stall state, touched only by the out-ready process
  int unsigned    stall_left  = 0;
  int unsigned    window_left = 0;
  bit             window_busy = 1'b0;

  point_in_polygon_test_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // monitor: every word moved on any channel goes to the checker
  // output first, so a query taken in the same edge queues behind the one
  // whose result is leaving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) book.check_result(out_word_o);
      if (cfg_valid_i && cfg_ready_o) book.note_count(cfg_data_i);
      if (in_valid_i && in_ready_o)   book.note_input(in_word_i);
    end
  end

  // receiver: windows of random length that either stall in random bursts
  // or never stall
  always @(posedge clk_i) begin
    if (quiet) begin
      stall_left = 0;
      out_ready_i <= 1'b1;
    end else begin
      if (window_left == 0) begin
        window_left = $urandom_range(200, 20);
        window_busy = $urandom_range(1, 0);
      end else begin
        window_left--;
      end
      if (stall_left != 0) stall_left--;
      else if (window_busy && $urandom_range(3, 0) == 0) stall_left = $urandom_range(11, 1);
      out_ready_i <= (stall_left == 0);
    end
  end

  // present one word and hold it until taken; valid stays high when the
  // next word follows without a gap
  task automatic send_word(input pip_pkg::in_word_t w);
    int unsigned gap;
    gap = 0;
    if (idle_on && !quiet && $urandom_range(3, 0) == 0) gap = $urandom_range(11, 1);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic write_vertex(input int unsigned slot, input logic signed [15:0] x,
                              input logic signed [15:0] y);
    pip_pkg::in_word_t w;
    w.cmd          = pip_pkg::CMD_WRITE;
    w.vertex_index = slot[7:0];
    w.coord_x      = x;
    w.coord_y      = y;
    slot_written[slot[7:0]] = 1'b1;
    send_word(w);
  endtask

  task automatic query_point(input logic signed [15:0] x, input logic signed [15:0] y);
    pip_pkg::in_word_t w;
    w.cmd          = pip_pkg::CMD_QUERY;
    w.vertex_index = 8'($urandom_range(255, 0));   // don't care on a query
    w.coord_x      = x;
    w.coord_y      = y;
    send_word(w);
  endtask

  // drop valid, wait for every result, then let a trailing vertex write land
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (book.pending() != 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_vertex_count(input logic [8:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // spread 0: tiny grid, lots of shared x/y; 1: moderate; else full range
  function automatic logic signed [15:0] pick_coord(input int unsigned spread);
    logic signed [15:0] v;
    case (spread)
      0: v = 16'(int'($urandom_range(16, 0)) - 8);
      1: v = 16'(int'($urandom_range(2000, 0)) - 1000);
      default: begin
        if ($urandom_range(15, 0) == 0) v = $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
        else v = 16'($urandom_range(65535, 0));
      end
    endcase
    return v;
  endfunction

  // query point, often on a vertex height so the half-open y rule is hit
  task automatic ask_near(input int n, input int unsigned spread);
    int                 k;
    logic signed [15:0] x, y;
    x = pick_coord(spread);
    y = pick_coord(spread);
    if (n > 0 && $urandom_range(2, 0) == 0) begin
      k = $urandom_range(n - 1, 0);
      y = book.vert_y[k];
      if ($urandom_range(1, 0)) x = book.vert_x[k];
    end else if ($urandom_range(5, 0) == 0) begin
      x = pick_coord(2);
      y = pick_coord(2);
    end
    query_point(x, y);
  endtask

  initial begin
    int          phase, big_idx, m, queries;
    int unsigned spread;
    logic [8:0]  count;
    logic [8:0]  big_counts [4];

    book = new();
    big_counts[0] = 9'd256;
    big_counts[1] = 9'd511;   // above capacity, acts as full
    big_counts[2] = 9'd300;
    big_counts[3] = 9'd255;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // empty polygon straight out of reset
    query_point(16'sh8000, 16'sh7fff);
    write_vertex(0, 16'sh8000, 16'sh8000);

    // single vertex: only a degenerate edge
    set_vertex_count(9'd1);
    query_point(16'sh8000, 16'sh8000);
    query_point(16'sh0000, 16'sh0000);

    // full-range square, probed on each side, corner and center
    write_vertex(1, 16'sh7fff, 16'sh8000);
    write_vertex(2, 16'sh7fff, 16'sh7fff);
    write_vertex(3, 16'sh8000, 16'sh7fff);
    set_vertex_count(9'd4);
    query_point(16'sh0000, 16'sh0000);
    query_point(16'sh8000, 16'sh0000);
    query_point(16'sh7fff, 16'sh0000);
    query_point(16'sh0000, 16'sh7fff);
    query_point(16'sh0000, 16'sh8000);
    query_point(16'sh7fff, 16'sh7fff);
    query_point(16'sh8000, 16'sh8001);

    // top slot, then a triangle with sloped edges over slots 0..2
    write_vertex(255, 16'sh7fff, 16'shffff);
    write_vertex(0, -16'sd100, -16'sd100);
    write_vertex(1, 16'sd100, -16'sd50);
    write_vertex(2, 16'sd0, 16'sd120);
    set_vertex_count(9'd3);
    query_point(16'sd0, -16'sd75);    // on the bottom edge
    query_point(16'sd100, -16'sd50);  // on a vertex
    query_point(-16'sd50, 16'sd10);   // on the left edge
    query_point(16'sd0, 16'sd120);    // apex
    query_point(16'sd50, 16'sd35);    // on the right edge

    // ---- random polygons ----
    phase   = 0;
    big_idx = 0;
    while (items_sent < ItemGoal) begin
      if (items_sent >= QuietFrom) quiet <= 1'b1;
      idle_on = ($urandom_range(2, 0) != 0);
      spread  = $urandom_range(2, 0);

      if (phase % 10 == 4 && big_idx < 4) begin
        count = big_counts[big_idx];
        big_idx++;
      end else begin
        case ($urandom_range(15, 0))
          0:       count = 9'd0;
          1:       count = 9'd1;
          2:       count = 9'd2;
          default: count = 9'($urandom_range(12, 3));
        endcase
      end
      m = (count > 9'd256) ? 256 : int'(count);

      set_vertex_count(count);
      // a full-size polygon is laid down once; later large phases reuse it
      for (int k = 0; k < m; k++)
        if (m < 255 || !slot_written[k]) write_vertex(k, pick_coord(spread), pick_coord(spread));

      queries = (m > 16) ? 8 : $urandom_range(18, 8);
      repeat (queries) begin
        // stray vertex write anywhere, now and then reshaping the polygon
        if ($urandom_range(7, 0) == 0)
          write_vertex($urandom_range(255, 0), pick_coord(2), pick_coord(2));
        ask_near(m, spread);
      end
      phase++;
    end

    quiet <= 1'b1;
    wait_idle();
    if (book.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
